// ===== sv/sws_pkg.sv =====
// Shared types and constants of the sliding window sender.
package sws_pkg;

    // Most frame descriptors that one send or resend request may produce.
    localparam int MAX_FRAMES = 60;
    localparam int FCNT_W     = 6;

    localparam int WINDOW_W   = 16;
    localparam int OFFSET_W   = 32;
    localparam int FLEN_W     = 11;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd4096;

    // Action codes carried in s_tuser.
    localparam logic [1:0] ACT_SEND   = 2'd0;
    localparam logic [1:0] ACT_RESEND = 2'd1;
    localparam logic [1:0] ACT_ACK    = 2'd2;
    // The remaining code is dropped without a result.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Result kinds carried in m_tuser.
    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_ACK_OK  = 2'd1;
    localparam logic [1:0] KIND_ACK_BAD = 2'd2;

    // Configuration register indexes.
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_TOTAL  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WEND,
        ST_LIMIT,
        ST_START,
        ST_FRAMES,
        ST_ACK
    } state_t;

    // Status of one segmentation step.
    typedef struct packed {
        logic seg_last;   // this frame reaches the limit of the run
        logic fin;        // this frame ends at the transfer length
    } seg_flags_t;

endpackage

// ===== sv/sliding_window_sender.sv =====
// Top level of the sliding window sender: session state, sequencer and output word register.
//
// This block cuts a buffered transfer into frame descriptors under a byte-offset sliding
// window (go-back-N style). An input word carries an action in s_tuser and an acknowledged
// offset in s_tdata. Send-next emits frames from the send pointer, each at most FRAME_BYTES
// long and cut at the window end and at the transfer end, then advances the pointer. Resend
// re-emits the frames between the window head and the send pointer. An acknowledgement
// moves the head forward and answers with one accepted or rejected word. The unused action
// code is swallowed without a result. Writing total_length restarts the session. Timing: the
// block takes one input word at a time and drops s_tready until every result of it has been
// loaded into the output register. An acknowledgement is answered from the acknowledgement
// state once the output register is free. A send or resend is accepted and then sets up the
// window end, the run limit, and then the start offset and run length together, and then
// emits one frame per cycle through the segmentation step unit, up to sixty frames, while
// m_tready keeps the output register free; it stalls while the register is held full. A
// request with nothing to send finishes after the setup with no result. The last result is
// still being offered on the output while the next input word is taken.
module sliding_window_sender #(
    parameter int FRAME_BYTES = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_addr,
    input  logic [31:0] cfg_wr_data,

    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] ack_number
    input  logic [1:0]  s_tuser,    // [1:0] action

    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [31:0] frame_offset, [42:32] frame_bytes,
                                    // [43] final_frame, [44] final_acked, [47:45] zero
    output logic [1:0]  m_tuser,    // [1:0] result_kind
    output logic        m_tlast     // last_of_run
);

    localparam int OW    = sws_pkg::OFFSET_W;
    localparam int LEN_W = $clog2(FRAME_BYTES + 1);
    // The effective window never exceeds sixty frames.
    localparam logic [OW-1:0] WIN_CAP = OW'(sws_pkg::MAX_FRAMES * FRAME_BYTES);

    sws_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [sws_pkg::WINDOW_W-1:0] window_reg;
    logic [OW-1:0]                total_reg;

    // Session state.
    logic [OW-1:0] head_reg;
    logic [OW-1:0] ptr_reg;
    logic          fpend_reg;
    logic [OW-1:0] fseq_reg;
    logic          facked_reg;

    // Captured input word.
    logic [1:0]    act_reg;
    logic [OW-1:0] ack_reg;

    // Run registers of the sequencer.
    logic [OW:0]                 wend_reg;
    logic [OW-1:0]               lim_reg;
    logic                        lim_tot_reg;
    logic [OW-1:0]               cursor_reg;
    logic [OW-1:0]               rem_reg;
    logic [sws_pkg::FCNT_W-1:0]  fcnt_reg;

    // Output word register.
    logic                      m_tvalid_reg;
    logic [1:0]                m_kind_reg;
    logic [OW-1:0]             m_off_reg;
    logic [sws_pkg::FLEN_W-1:0] m_len_reg;
    logic                      m_fin_reg;
    logic                      m_facked_reg;
    logic                      m_last_reg;

    // Control strobes from the sequencer.
    logic in_take;
    logic out_free;
    logic do_wend;
    logic do_limit;
    logic do_start;
    logic emit_frame;
    logic emit_ack;

    // Datapath values.
    logic [sws_pkg::WINDOW_W-1:0] wcap;
    logic [OW-1:0]                bound;
    logic [OW-1:0]                start;
    logic                         wend_below;
    logic [OW:0]                  run_diff;
    logic                         run_empty;
    logic                         run_end;
    logic                         ack_hit;
    logic                         ack_ok;

    logic [LEN_W-1:0]      seg_len;
    logic [OW-1:0]         seg_next_cursor;
    logic [OW-1:0]         seg_next_rem;
    sws_pkg::seg_flags_t   seg_flags;

    sws_seg_step #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_seg (
        .cursor_i      (cursor_reg),
        .rem_i         (rem_reg),
        .lim_total_i   (lim_tot_reg),
        .len_o         (seg_len),
        .next_cursor_o (seg_next_cursor),
        .next_rem_o    (seg_next_rem),
        .flags_o       (seg_flags)
    );

    // Oversized windows act as sixty frames.
    assign wcap = (OW'(window_reg) > WIN_CAP) ? sws_pkg::WINDOW_W'(WIN_CAP) : window_reg;

    // Send runs up to the smaller of window end and transfer end, starting at the send
    // pointer. Resend runs from the head up to the smaller of window end and send pointer.
    assign bound      = (act_reg == sws_pkg::ACT_SEND) ? total_reg : ptr_reg;
    assign start      = (act_reg == sws_pkg::ACT_SEND) ? ptr_reg : head_reg;
    assign wend_below = (wend_reg < {1'b0, bound});

    // A borrow means the start lies past the limit, as after a shrunken window.
    assign run_diff  = {1'b0, lim_reg} - {1'b0, start};
    assign run_empty = run_diff[OW] || (run_diff[OW-1:0] == '0);

    assign run_end = seg_flags.seg_last ||
                     (fcnt_reg == sws_pkg::FCNT_W'(sws_pkg::MAX_FRAMES - 1));

    assign ack_hit = fpend_reg && (ack_reg == fseq_reg);
    assign ack_ok  = (ack_reg <= ptr_reg);

    assign out_free = !m_tvalid_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sws_pkg::ST_IDLE: begin
                if (in_take) begin
                    if (s_tuser == sws_pkg::ACT_ACK) begin
                        state_next = sws_pkg::ST_ACK;
                    end else if (s_tuser == sws_pkg::ACT_SEND ||
                                 s_tuser == sws_pkg::ACT_RESEND) begin
                        state_next = sws_pkg::ST_WEND;
                    end
                end
            end
            sws_pkg::ST_WEND:  state_next = sws_pkg::ST_LIMIT;
            sws_pkg::ST_LIMIT: state_next = sws_pkg::ST_START;
            sws_pkg::ST_START: begin
                state_next = run_empty ? sws_pkg::ST_IDLE : sws_pkg::ST_FRAMES;
            end
            sws_pkg::ST_FRAMES: begin
                if (out_free && run_end) begin
                    state_next = sws_pkg::ST_IDLE;
                end
            end
            sws_pkg::ST_ACK: begin
                if (out_free) begin
                    state_next = sws_pkg::ST_IDLE;
                end
            end
            default: state_next = sws_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready   = 1'b0;
        do_wend    = 1'b0;
        do_limit   = 1'b0;
        do_start   = 1'b0;
        emit_frame = 1'b0;
        emit_ack   = 1'b0;
        case (state_reg)
            sws_pkg::ST_IDLE:   s_tready   = 1'b1;
            sws_pkg::ST_WEND:   do_wend    = 1'b1;
            sws_pkg::ST_LIMIT:  do_limit   = 1'b1;
            sws_pkg::ST_START:  do_start   = !run_empty;
            sws_pkg::ST_FRAMES: emit_frame = out_free;
            sws_pkg::ST_ACK:    emit_ack   = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sws_pkg::ST_IDLE;
            window_reg   <= sws_pkg::WINDOW_RESET;
            total_reg    <= '0;
            head_reg     <= '0;
            ptr_reg      <= '0;
            fpend_reg    <= 1'b0;
            fseq_reg     <= '0;
            facked_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (in_take) begin
                act_reg <= s_tuser;
                ack_reg <= s_tdata;
            end

            if (do_wend) begin
                wend_reg <= {1'b0, head_reg} + (OW + 1)'(wcap);
            end

            // The run limit equals the transfer end only when the window reaches at least to the
            // bound and the bound itself is the transfer end.
            if (do_limit) begin
                lim_reg     <= wend_below ? wend_reg[OW-1:0] : bound;
                lim_tot_reg <= !wend_below &&
                               (act_reg == sws_pkg::ACT_SEND || ptr_reg == total_reg);
            end

            if (do_start) begin
                cursor_reg <= start;
                rem_reg    <= run_diff[OW-1:0];
                fcnt_reg   <= '0;
            end

            if (emit_frame) begin
                cursor_reg <= seg_next_cursor;
                rem_reg    <= seg_next_rem;
                fcnt_reg   <= fcnt_reg + 1'b1;
                if (act_reg == sws_pkg::ACT_SEND) begin
                    ptr_reg <= seg_next_cursor;
                    if (seg_flags.fin) begin
                        fpend_reg <= 1'b1;
                        fseq_reg  <= cursor_reg;
                    end
                end
            end

            if (emit_ack) begin
                if (ack_hit) begin
                    fpend_reg  <= 1'b0;
                    facked_reg <= 1'b1;
                end
                if (ack_ok && ack_reg > head_reg) begin
                    head_reg <= ack_reg;
                end
            end

            if (emit_frame || emit_ack) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // The user must write configuration only while idle; the block itself does not enforce this.
            if (cfg_wr_en) begin
                if (cfg_wr_addr == sws_pkg::REG_WINDOW) begin
                    window_reg <= cfg_wr_data[sws_pkg::WINDOW_W-1:0];
                end else begin
                    total_reg  <= cfg_wr_data;
                    head_reg   <= '0;
                    ptr_reg    <= '0;
                    fpend_reg  <= 1'b0;
                    fseq_reg   <= '0;
                    facked_reg <= 1'b0;
                end
            end
        end
    end

    // Output word payload.
    always_ff @(posedge aclk) begin
        if (emit_frame) begin
            m_kind_reg   <= sws_pkg::KIND_FRAME;
            m_off_reg    <= cursor_reg;
            m_len_reg    <= sws_pkg::FLEN_W'(seg_len);
            m_fin_reg    <= seg_flags.fin;
            m_facked_reg <= facked_reg;
            m_last_reg   <= run_end;
        end else if (emit_ack) begin
            m_kind_reg   <= ack_ok ? sws_pkg::KIND_ACK_OK : sws_pkg::KIND_ACK_BAD;
            m_off_reg    <= '0;
            m_len_reg    <= '0;
            m_fin_reg    <= 1'b0;
            m_facked_reg <= facked_reg || ack_hit;
            m_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_facked_reg, m_fin_reg, m_len_reg, m_off_reg};

    // The send pointer never runs past the end of the transfer.
    a_ptr_in_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= total_reg)
        else $error("send pointer beyond transfer length");

    // The window head never passes the send pointer.
    a_head_behind_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= ptr_reg)
        else $error("window head ahead of send pointer");

    // A run never exceeds the frame limit.
    a_frame_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sws_pkg::ST_FRAMES |-> fcnt_reg < sws_pkg::FCNT_W'(sws_pkg::MAX_FRAMES))
        else $error("frame count past limit");

    // An accepted acknowledgement word always moves the sequencer to the acknowledgement state.
    a_ack_path: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take && s_tuser == sws_pkg::ACT_ACK |=> state_reg == sws_pkg::ST_ACK)
        else $error("acknowledgement not sequenced");

endmodule

// ===== sv/sws_seg_step.sv =====
// Segmentation step unit: cuts one frame off the bytes left before the limit.
module sws_seg_step #(
    parameter int FRAME_BYTES = 1024
) (
    input  logic [sws_pkg::OFFSET_W-1:0]        cursor_i,
    input  logic [sws_pkg::OFFSET_W-1:0]        rem_i,
    input  logic                                lim_total_i,
    output logic [$clog2(FRAME_BYTES+1)-1:0]    len_o,
    output logic [sws_pkg::OFFSET_W-1:0]        next_cursor_o,
    output logic [sws_pkg::OFFSET_W-1:0]        next_rem_o,
    output sws_pkg::seg_flags_t                 flags_o
);

    localparam int LEN_W = $clog2(FRAME_BYTES + 1);
    localparam logic [sws_pkg::OFFSET_W-1:0] FB_W = sws_pkg::OFFSET_W'(FRAME_BYTES);

    logic short_seg;

    // The last frame of a run is the one that fits entirely in what is left.
    assign short_seg     = (rem_i <= FB_W);
    assign len_o         = short_seg ? rem_i[LEN_W-1:0] : LEN_W'(FRAME_BYTES);
    assign next_cursor_o = cursor_i + sws_pkg::OFFSET_W'(len_o);
    assign next_rem_o    = rem_i - sws_pkg::OFFSET_W'(len_o);

    assign flags_o.seg_last = short_seg;
    assign flags_o.fin      = short_seg & lim_total_i;

endmodule
